### hw/rtl/spudec_pkg.sv
`timescale 1ns / 1ps

package spudec_pkg;

	// Fixed field widths of the stream.
	localparam int BYTE_W   = 8;
	localparam int NIB_W    = 4;
	localparam int SAMPLE_W = 16;
	localparam int LOOP_W   = 20;
	localparam int FLAGS_W  = 8;
	localparam int POS_W    = 4;
	localparam int COEF_W   = 8;

	// Block layout.
	localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
	localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
	localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

	// Block flag bits.
	localparam int FLAG_END  = 0;
	localparam int FLAG_LOOP = 2;
	localparam logic [FLAGS_W-1:0] FLAGS_END_REPEAT = 8'd3;

	// Samples per block.
	localparam int SAMPLES_PER_BLOCK = 28;

	// Default block limit.
	localparam int MAX_BLOCKS_DEF = 32768;

	// Depth of the queue between the byte parser and the sample engine.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Predictor filter codes.
	localparam logic [NIB_W-1:0] FILT_NONE = 4'd0;
	localparam logic [NIB_W-1:0] FILT_ONE  = 4'd1;
	localparam logic [NIB_W-1:0] FILT_TWO  = 4'd2;
	localparam logic [NIB_W-1:0] FILT_THREE = 4'd3;
	localparam logic [NIB_W-1:0] FILT_FOUR = 4'd4;

	// One data byte with everything the sample engine needs to decode it.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [NIB_W-1:0]  shift;
		logic [NIB_W-1:0]  filter;
		logic              clr_hist;
		logic              blk_end;
		logic              loop_seen;
		logic [LOOP_W-1:0] loop_index;
		logic              tone_end;
		logic              forced_stop;
	} entry_t;

	// Queue status seen by the parser and the sample engine.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Coefficient for the newest history sample. Unknown filters predict nothing.
	function automatic logic signed [COEF_W-1:0] coef_h1(input logic [NIB_W-1:0] f);
		logic signed [COEF_W-1:0] c;
		case (f)
			FILT_ONE:   c = 8'sd60;
			FILT_TWO:   c = 8'sd115;
			FILT_THREE: c = 8'sd98;
			FILT_FOUR:  c = 8'sd122;
			default:    c = 8'sd0;
		endcase
		return c;
	endfunction

	// Coefficient for the older history sample.
	function automatic logic signed [COEF_W-1:0] coef_h2(input logic [NIB_W-1:0] f);
		logic signed [COEF_W-1:0] c;
		case (f)
			FILT_TWO:   c = -8'sd52;
			FILT_THREE: c = -8'sd55;
			FILT_FOUR:  c = -8'sd60;
			default:    c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/spudec_front.sv
`timescale 1ns / 1ps

module spudec_front #(
	parameter int MAX_BLOCKS = spudec_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spudec_pkg::BYTE_W-1:0] in_byte,
	input  logic                          in_start,
	input  spudec_pkg::q_status_t         q_stat,
	output logic                          q_push,
	output spudec_pkg::entry_t            q_entry
);
	import spudec_pkg::*;

	localparam int BC_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [BC_W-1:0] BC_MAX = BC_W'(MAX_BLOCKS - 1);

	logic [POS_W-1:0]   pos_q;
	logic [NIB_W-1:0]   shift_q;
	logic [NIB_W-1:0]   filter_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [BC_W-1:0]    bc_q;
	logic               finished_q;
	logic               clr_pend_q;

	logic               accept;
	logic [POS_W-1:0]   pos_eff;
	logic               fin_eff;
	logic               is_data;
	logic [31:0]        bc_ext;
	logic [31:0]        bc_x28;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// A tone start restarts the block parse on this very byte.
	assign pos_eff = in_start ? POS_HEADER : pos_q;
	assign fin_eff = in_start ? 1'b0 : finished_q;
	assign is_data = !fin_eff && (pos_eff != POS_HEADER) && (pos_eff != POS_FLAGS);

	// Block count times 28 as (x << 5) - (x << 2).
	assign bc_ext = 32'(bc_q);
	assign bc_x28 = (bc_ext << 5) - (bc_ext << 2);

	always_comb begin
		q_entry             = '0;
		q_entry.data        = in_byte;
		q_entry.shift       = shift_q;
		q_entry.filter      = filter_q;
		q_entry.clr_hist    = clr_pend_q;
		if (pos_eff == POS_LAST) begin
			q_entry.blk_end = 1'b1;
			if (flags_q[FLAG_LOOP]) begin
				q_entry.loop_seen  = 1'b1;
				q_entry.loop_index = bc_x28[LOOP_W-1:0];
			end else if (flags_q[FLAG_END]) begin
				q_entry.tone_end    = 1'b1;
				q_entry.forced_stop = (flags_q != FLAGS_END_REPEAT);
			end
		end
	end

	assign q_push = accept && is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			shift_q    <= '0;
			filter_q   <= '0;
			flags_q    <= '0;
			bc_q       <= '0;
			finished_q <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			if (in_start) begin
				flags_q    <= '0;
				bc_q       <= '0;
				finished_q <= 1'b0;
				clr_pend_q <= 1'b1;
			end
			if (!fin_eff) begin
				pos_q <= pos_eff + 1'b1;
				if (pos_eff == POS_HEADER) begin
					shift_q  <= in_byte[NIB_W-1:0];
					filter_q <= in_byte[BYTE_W-1:NIB_W];
				end else if (pos_eff == POS_FLAGS) begin
					flags_q <= in_byte;
				end else begin
					clr_pend_q <= 1'b0;
					if (pos_eff == POS_LAST) begin
						if (!flags_q[FLAG_LOOP] && flags_q[FLAG_END]) begin
							finished_q <= 1'b1;
						end
						if (bc_q < BC_MAX) begin
							bc_q <= bc_q + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

### hw/rtl/spudec_fifo.sv
`timescale 1ns / 1ps

module spudec_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spudec_pkg::entry_t    wr_entry,
	input  logic                  pop,
	output spudec_pkg::entry_t    rd_entry,
	output spudec_pkg::q_status_t stat
);
	import spudec_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/spudec_back.sv
`timescale 1ns / 1ps

module spudec_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spudec_pkg::q_status_t           q_stat,
	input  spudec_pkg::entry_t              q_entry,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [spudec_pkg::SAMPLE_W-1:0] out_sample,
	output logic                            out_pair_last,
	output logic                            out_blk_end,
	output logic                            out_loop_seen,
	output logic [spudec_pkg::LOOP_W-1:0]   out_loop_index,
	output logic                            out_tone_end,
	output logic                            out_forced_stop
);
	import spudec_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int SUM_W  = SAMPLE_W + 4;

	logic                       phase_q;
	logic signed [SAMPLE_W-1:0] h1_q;
	logic signed [SAMPLE_W-1:0] h2_q;
	logic                       valid_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       pair_last_q;
	logic                       blk_end_q;
	logic                       loop_seen_q;
	logic [LOOP_W-1:0]          loop_index_q;
	logic                       tone_end_q;
	logic                       forced_stop_q;

	logic                       fire;
	logic                       clr;
	logic [NIB_W-1:0]           nib;
	logic signed [SAMPLE_W-1:0] raw;
	logic signed [SAMPLE_W-1:0] scaled;
	logic signed [SAMPLE_W-1:0] h1_use;
	logic signed [SAMPLE_W-1:0] h2_use;
	logic signed [PROD_W-1:0]   p1;
	logic signed [PROD_W-1:0]   p2;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] sat;

	assign fire  = !q_stat.empty && (!valid_q || out_ready);
	assign q_pop = fire && phase_q;

	// History restarts at the first data byte of a new tone.
	assign clr    = q_entry.clr_hist && !phase_q;
	assign h1_use = clr ? '0 : h1_q;
	assign h2_use = clr ? '0 : h2_q;

	assign nib    = phase_q ? q_entry.data[BYTE_W-1:NIB_W] : q_entry.data[NIB_W-1:0];
	assign raw    = $signed({nib, {(SAMPLE_W-NIB_W){1'b0}}});
	assign scaled = raw >>> q_entry.shift;

	assign p1  = h1_use * coef_h1(q_entry.filter);
	assign p2  = h2_use * coef_h2(q_entry.filter);
	assign sum = SUM_W'(scaled) + SUM_W'(p1 >>> 6) + SUM_W'(p2 >>> 6);

	always_comb begin
		if (sum > SUM_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (sum < -SUM_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			h1_q    <= '0;
			h2_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= !phase_q;
				h1_q    <= sat;
				h2_q    <= h1_use;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q      <= sat;
			pair_last_q   <= phase_q;
			blk_end_q     <= phase_q && q_entry.blk_end;
			loop_seen_q   <= phase_q && q_entry.loop_seen;
			loop_index_q  <= phase_q ? q_entry.loop_index : '0;
			tone_end_q    <= phase_q && q_entry.tone_end;
			forced_stop_q <= phase_q && q_entry.forced_stop;
		end
	end

	assign out_valid       = valid_q;
	assign out_sample      = sample_q;
	assign out_pair_last   = pair_last_q;
	assign out_blk_end     = blk_end_q;
	assign out_loop_seen   = loop_seen_q;
	assign out_loop_index  = loop_index_q;
	assign out_tone_end    = tone_end_q;
	assign out_forced_stop = forced_stop_q;

endmodule

### hw/rtl/spu_adpcm_block_decoder.sv
`timescale 1ns / 1ps
// An accepted data byte is written into the queue, and its first sample is then registered in the sample engine.
// A data byte gives two samples through the single shared predictor of the
// sample engine; header, flag and ignored bytes never enter the queue.
// Reset: arst_n clears all control state and the predictor history asynchronously;
// the decoder is ready for a transaction as soon as reset is released.
module spu_adpcm_block_decoder #(
	parameter int MAX_BLOCKS = spudec_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream: one sound-RAM byte per transaction.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] tone_start
	// Output stream: one decoded sample per transaction.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] sample, [35:16] loop_index, [39:36] zero
	output logic        m_tlast,   // block_done
	output logic [3:0]  m_tuser    // [0] last_of_pair, [1] loop_start_seen,
	                               // [2] tone_end, [3] forced_stop
);
	import spudec_pkg::*;

	// The parser walks the 16-byte block layout, keeps shift, filter, flags and the
	// block count, and hands each data byte to the queue together with everything
	// the end of the block implies. The sample engine decodes the low nibble and
	// then the high nibble of each queued byte through the two-tap predictor.

	q_status_t           q_stat;
	entry_t              push_entry;
	entry_t              head_entry;
	logic                q_push;
	logic                q_pop;

	logic [SAMPLE_W-1:0] sample;
	logic [LOOP_W-1:0]   loop_index;
	logic                pair_last;
	logic                loop_seen;
	logic                tone_end;
	logic                forced_stop;

	spudec_front #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	spudec_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.stat     (q_stat)
	);

	spudec_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.q_entry         (head_entry),
		.q_pop           (q_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_sample      (sample),
		.out_pair_last   (pair_last),
		.out_blk_end     (m_tlast),
		.out_loop_seen   (loop_seen),
		.out_loop_index  (loop_index),
		.out_tone_end    (tone_end),
		.out_forced_stop (forced_stop)
	);

	assign m_tdata = {4'b0000, loop_index, sample};
	assign m_tuser = {forced_stop, tone_end, loop_seen, pair_last};

endmodule
